### hdl/dwtp_pkg.sv
// ----------------------------------------------------------------------------
// dwtp_pkg
// Shared widths, types and register codes of the differential turn PID.
// ----------------------------------------------------------------------------
package dwtp_pkg;

   localparam int CntW    = 16;   // encoder count
   localparam int TgtW    = 21;   // turn target
   localparam int GainW   = 16;   // Q8.8 gain
   localparam int TolW    = 8;    // done tolerance
   localparam int EffW    = 8;    // motor effort
   localparam int ErrW    = 22;   // wheel error
   localparam int DerW    = ErrW + 1;
   localparam int SumW    = 40;   // saturating integral
   localparam int SumLoW  = 20;   // low slice of the integral for the split multiply
   localparam int SumHiW  = SumW - SumLoW;
   localparam int AccW    = 58;   // full Q.8 accumulator
   localparam int FracW   = 8;
   localparam int CsrIdxW = 3;

   localparam int EffortLimit    = 80;
   localparam int ToleranceReset = 10;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_TARGET_COUNTS  = 3'd0,
      CSR_LEFT_KP        = 3'd1,
      CSR_LEFT_KI        = 3'd2,
      CSR_LEFT_KD        = 3'd3,
      CSR_RIGHT_KP       = 3'd4,
      CSR_RIGHT_KI       = 3'd5,
      CSR_RIGHT_KD       = 3'd6,
      CSR_DONE_TOLERANCE = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [GainW-1:0] kp;
      logic signed [GainW-1:0] ki;
      logic signed [GainW-1:0] kd;
   } gain_type;

   // error, updated integral and derivative of one wheel for one beat
   typedef struct packed {
      logic signed [ErrW-1:0] err;
      logic signed [SumW-1:0] sum;
      logic signed [DerW-1:0] der;
   } wheel_term_type;

endpackage

### hdl/dual_wheel_turn_pid.sv
// ----------------------------------------------------------------------------
// dual_wheel_turn_pid
// Two-wheel differential turn PID with saturating integrals and done flag.
// ----------------------------------------------------------------------------
// A beat passes s1, the wheel state, the products and the response register.
// Throughput: one beat per cycle; the four-deep pipeline stalls as one unit.
// Wheel state updates in the second stage, products in the third.
// Reset clears gains, target, integrals, prior errors, done; tolerance to 10.
// ----------------------------------------------------------------------------
module dual_wheel_turn_pid (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_action,
   input  logic signed [dwtp_pkg::CntW-1:0]    req_left_count,
   input  logic signed [dwtp_pkg::CntW-1:0]    req_right_count,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [dwtp_pkg::EffW-1:0]    rsp_left_effort,
   output logic signed [dwtp_pkg::EffW-1:0]    rsp_right_effort,
   output logic                                rsp_turn_done,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic        [dwtp_pkg::CsrIdxW-1:0] csr_index,
   input  logic        [dwtp_pkg::TgtW-1:0]    csr_data
);
   import dwtp_pkg::*;

   logic signed [TgtW-1:0] target_ff;
   gain_type               left_gain_ff, right_gain_ff;
   logic        [TolW-1:0] tol_ff;

   logic                   s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;
   logic                   s1_action_ff;
   logic signed [CntW-1:0] s1_left_ff, s1_right_ff;
   logic                   s3_done_ff;
   logic signed [EffW-1:0] rsp_left_ff, rsp_right_ff;
   logic                   rsp_done_ff;

   logic                   advance;
   wheel_term_type         left_term, right_term;
   logic                   s2_done;
   logic signed [EffW-1:0] left_effort, right_effort;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff     <= '0;
         left_gain_ff  <= '0;
         right_gain_ff <= '0;
         tol_ff        <= TolW'(ToleranceReset);
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_TARGET_COUNTS:  target_ff        <= csr_data;
            CSR_LEFT_KP:        left_gain_ff.kp  <= csr_data[GainW-1:0];
            CSR_LEFT_KI:        left_gain_ff.ki  <= csr_data[GainW-1:0];
            CSR_LEFT_KD:        left_gain_ff.kd  <= csr_data[GainW-1:0];
            CSR_RIGHT_KP:       right_gain_ff.kp <= csr_data[GainW-1:0];
            CSR_RIGHT_KI:       right_gain_ff.ki <= csr_data[GainW-1:0];
            CSR_RIGHT_KD:       right_gain_ff.kd <= csr_data[GainW-1:0];
            CSR_DONE_TOLERANCE: tol_ff           <= csr_data[TolW-1:0];
            default:            ;
         endcase
      end
   end

   // whole pipe moves unless a finished beat is held at the output
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= req_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_action_ff <= req_action;
         s1_left_ff   <= req_left_count;
         s1_right_ff  <= req_right_count;
         s3_done_ff   <= s2_done;
         rsp_left_ff  <= left_effort;
         rsp_right_ff <= right_effort;
         rsp_done_ff  <= s3_done_ff;
      end
   end

   dwtp_state u_state (
      .clock          (clock),
      .reset          (reset),
      .step           (advance && s1_valid_ff),
      .clear          (s1_action_ff),
      .left_count     (s1_left_ff),
      .right_count    (s1_right_ff),
      .target_counts  (target_ff),
      .done_tolerance (tol_ff),
      .left_term      (left_term),
      .right_term     (right_term),
      .done           (s2_done)
   );

   dwtp_effort u_left (
      .clock  (clock),
      .enable (advance),
      .term   (left_term),
      .gain   (left_gain_ff),
      .effort (left_effort)
   );

   dwtp_effort u_right (
      .clock  (clock),
      .enable (advance),
      .term   (right_term),
      .gain   (right_gain_ff),
      .effort (right_effort)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_left_effort  = rsp_left_ff;
   assign rsp_right_effort = rsp_right_ff;
   assign rsp_turn_done    = rsp_done_ff;

endmodule

### hdl/dwtp_state.sv
// ----------------------------------------------------------------------------
// dwtp_state
// Wheel errors, saturating integrals, previous errors and sticky done flag.
// ----------------------------------------------------------------------------
module dwtp_state (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             step,
   input  logic                             clear,
   input  logic signed [dwtp_pkg::CntW-1:0] left_count,
   input  logic signed [dwtp_pkg::CntW-1:0] right_count,
   input  logic signed [dwtp_pkg::TgtW-1:0] target_counts,
   input  logic        [dwtp_pkg::TolW-1:0] done_tolerance,
   output dwtp_pkg::wheel_term_type         left_term,
   output dwtp_pkg::wheel_term_type         right_term,
   output logic                             done
);
   import dwtp_pkg::*;

   logic signed [SumW-1:0] left_sum_ff, left_sum_in;
   logic signed [SumW-1:0] right_sum_ff, right_sum_in;
   logic signed [ErrW-1:0] left_prev_ff, left_prev_in;
   logic signed [ErrW-1:0] right_prev_ff, right_prev_in;
   logic signed [DerW-1:0] left_der_ff, left_der_in;
   logic signed [DerW-1:0] right_der_ff, right_der_in;
   logic                   done_ff, done_in;

   logic signed [ErrW-1:0] left_err, right_err;
   logic signed [SumW:0]   left_ext, right_ext;
   logic        [ErrW-1:0] left_abs, right_abs;
   logic        [CntW:0]   left_cnt_abs, right_cnt_abs;
   logic signed [CntW+1:0] cnt_diff;
   logic        [CntW:0]   cnt_diff_abs;
   logic                   in_band;

   localparam logic signed [SumW-1:0] SumMax = {1'b0, {(SumW-1){1'b1}}};
   localparam logic signed [SumW-1:0] SumMin = {1'b1, {(SumW-1){1'b0}}};

   always_comb begin
      left_err  = -ErrW'(target_counts) - ErrW'(left_count);
      right_err =  ErrW'(target_counts) - ErrW'(right_count);

      left_ext  = (SumW+1)'(left_sum_ff)  + (SumW+1)'(left_err);
      right_ext = (SumW+1)'(right_sum_ff) + (SumW+1)'(right_err);

      // overflow when the two top bits disagree
      if (left_ext[SumW] != left_ext[SumW-1]) begin
         left_sum_in = left_ext[SumW] ? SumMin : SumMax;
      end else begin
         left_sum_in = left_ext[SumW-1:0];
      end
      if (right_ext[SumW] != right_ext[SumW-1]) begin
         right_sum_in = right_ext[SumW] ? SumMin : SumMax;
      end else begin
         right_sum_in = right_ext[SumW-1:0];
      end

      left_der_in   = DerW'(left_err)  - DerW'(left_prev_ff);
      right_der_in  = DerW'(right_err) - DerW'(right_prev_ff);
      left_prev_in  = left_err;
      right_prev_in = right_err;

      left_abs      = left_err[ErrW-1]  ? ErrW'(-left_err)  : ErrW'(left_err);
      right_abs     = right_err[ErrW-1] ? ErrW'(-right_err) : ErrW'(right_err);
      left_cnt_abs  = left_count[CntW-1]  ? -(CntW+1)'(left_count)  : (CntW+1)'(left_count);
      right_cnt_abs = right_count[CntW-1] ? -(CntW+1)'(right_count) : (CntW+1)'(right_count);
      cnt_diff      = $signed({1'b0, left_cnt_abs}) - $signed({1'b0, right_cnt_abs});
      cnt_diff_abs  = cnt_diff[CntW+1] ? (CntW+1)'(-cnt_diff) : (CntW+1)'(cnt_diff);

      in_band = (left_abs < ErrW'(done_tolerance)) &&
                (right_abs < ErrW'(done_tolerance)) &&
                (cnt_diff_abs < (CntW+1)'(done_tolerance));
      done_in = done_ff | in_band;

      if (clear) begin
         left_sum_in   = '0;
         right_sum_in  = '0;
         left_prev_in  = '0;
         right_prev_in = '0;
         left_der_in   = '0;
         right_der_in  = '0;
         done_in       = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_sum_ff   <= '0;
         right_sum_ff  <= '0;
         left_prev_ff  <= '0;
         right_prev_ff <= '0;
         done_ff       <= 1'b0;
      end else if (step) begin
         left_sum_ff   <= left_sum_in;
         right_sum_ff  <= right_sum_in;
         left_prev_ff  <= left_prev_in;
         right_prev_ff <= right_prev_in;
         done_ff       <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         left_der_ff  <= left_der_in;
         right_der_ff <= right_der_in;
      end
   end

   // state after the last beat doubles as this stage's payload
   assign left_term  = '{err: left_prev_ff,  sum: left_sum_ff,  der: left_der_ff};
   assign right_term = '{err: right_prev_ff, sum: right_sum_ff, der: right_der_ff};
   assign done       = done_ff;

endmodule

### hdl/dwtp_effort.sv
// ----------------------------------------------------------------------------
// dwtp_effort
// Registered PID products of one wheel, then sum, floor and clamp.
// ----------------------------------------------------------------------------
module dwtp_effort (
   input  logic                             clock,
   input  logic                             enable,
   input  dwtp_pkg::wheel_term_type         term,
   input  dwtp_pkg::gain_type               gain,
   output logic signed [dwtp_pkg::EffW-1:0] effort
);
   import dwtp_pkg::*;

   localparam int PW  = GainW + ErrW;
   localparam int DW  = GainW + DerW;
   localparam int HiW = GainW + SumHiW;
   localparam int LoW = GainW + SumLoW + 1;
   localparam int QW  = AccW - FracW;

   localparam logic signed [QW-1:0] LimHi = QW'(EffortLimit);
   localparam logic signed [QW-1:0] LimLo = -QW'(EffortLimit);

   logic signed [PW-1:0]  p_ff;
   logic signed [DW-1:0]  d_ff;
   logic signed [HiW-1:0] i_hi_ff;
   logic signed [LoW-1:0] i_lo_ff;

   logic signed [SumHiW-1:0] sum_hi;
   logic signed [SumLoW:0]   sum_lo;
   logic signed [AccW-1:0]   acc;
   logic signed [QW-1:0]     q;

   assign sum_hi = term.sum[SumW-1:SumLoW];
   assign sum_lo = $signed({1'b0, term.sum[SumLoW-1:0]});

   // integral term split in two narrow multiplies
   always_ff @(posedge clock) begin
      if (enable) begin
         p_ff    <= PW'(gain.kp)  * PW'(term.err);
         d_ff    <= DW'(gain.kd)  * DW'(term.der);
         i_hi_ff <= HiW'(gain.ki) * HiW'(sum_hi);
         i_lo_ff <= LoW'(gain.ki) * LoW'(sum_lo);
      end
   end

   always_comb begin
      acc = AccW'(p_ff) + AccW'(d_ff) + AccW'(i_lo_ff) + (AccW'(i_hi_ff) <<< SumLoW);
      q   = QW'(acc >>> FracW);   // floor
      if (q > LimHi) begin
         effort = EffW'(LimHi);
      end else if (q < LimLo) begin
         effort = EffW'(LimLo);
      end else begin
         effort = EffW'(q);
      end
   end

endmodule
